FILE: src/qalu_pkg.sv
// qalu_pkg: shared widths, opcode type, payload structs and the rounding and clamping
// functions of the quaternion unit. No dependencies.
`default_nettype none

package qalu_pkg;

    localparam int WIDTH     = 32;
    localparam int FRAC_BITS = 16;

    // exact product and sum widths
    localparam int PROD_W = 2 * WIDTH;
    localparam int SUM_W  = PROD_W + 2;
    localparam int SQ_W   = PROD_W + 1;
    localparam int ROOT_W = WIDTH + 1;
    // quotient bits: the inverse can reach 2^(2*FRAC_BITS)
    localparam int QB     = 2 * FRAC_BITS + 1;
    localparam int INV_W  = WIDTH + 2 * FRAC_BITS + 1;
    localparam int DIV_W  = ((INV_W > SQ_W) ? INV_W : SQ_W) + 1;

    localparam logic signed [SUM_W-1:0] SAT_MAX =
        {{(SUM_W - WIDTH + 1){1'b0}}, {(WIDTH - 1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SAT_MIN =
        {{(SUM_W - WIDTH + 1){1'b1}}, {(WIDTH - 1){1'b0}}};
    localparam logic signed [SUM_W-1:0] RND_HALF =
        {{(SUM_W - FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS - 1){1'b0}}};

    typedef enum logic [2:0] {
        CMD_MUL  = 3'd0,
        CMD_CONJ = 3'd1,
        CMD_DOT  = 3'd2,
        CMD_NORM = 3'd3,
        CMD_INV  = 3'd4,
        CMD_UNIT = 3'd5
    } t_cmd;

    typedef struct packed {
        t_cmd                  cmd;
        logic [3:0][WIDTH-1:0] a;
        logic [3:0][WIDTH-1:0] b;
    } t_req;

    typedef struct packed {
        logic signed [WIDTH-1:0] x;
        logic signed [WIDTH-1:0] y;
        logic signed [WIDTH-1:0] z;
        logic signed [WIDTH-1:0] w;
        logic signed [WIDTH-1:0] s;
        logic                    zd;
        logic                    sat;
    } t_res;

    // what the front end hands to the root and divide stages
    typedef struct packed {
        t_cmd                  cmd;
        t_res                  res;
        logic [SQ_W-1:0]       sq;
        logic [3:0][WIDTH-1:0] mag;
        logic [3:0]            neg;
    } t_front;

    typedef struct packed {
        logic signed [WIDTH-1:0] val;
        logic                    sat;
    } t_sat;

    function automatic t_sat clamp_fn(input logic signed [SUM_W-1:0] v);
        t_sat r;
        if (v > SAT_MAX) begin
            r.val = SAT_MAX[WIDTH-1:0];
            r.sat = 1'b1;
        end else if (v < SAT_MIN) begin
            r.val = SAT_MIN[WIDTH-1:0];
            r.sat = 1'b1;
        end else begin
            r.val = v[WIDTH-1:0];
            r.sat = 1'b0;
        end
        return r;
    endfunction

    // round to nearest, ties away from zero, dropping FRAC_BITS
    function automatic logic signed [SUM_W-1:0] rnd_fn(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] t;
        t = v + RND_HALF - $signed({{(SUM_W - 1){1'b0}}, v[SUM_W-1]});
        return t >>> FRAC_BITS;
    endfunction

    function automatic logic signed [SUM_W-1:0] sext_fn(input logic [WIDTH-1:0] v);
        return $signed({{(SUM_W - WIDTH){v[WIDTH-1]}}, v});
    endfunction

endpackage

`default_nettype wire

FILE: src/qalu_if.sv
// qalu_if: request and result channels of the quaternion unit, valid/ready handshake.
// Depends on qalu_pkg for the component width.
`default_nettype none

interface qalu_req_if import qalu_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [2:0]              cmd;
    logic signed [WIDTH-1:0] a_x;
    logic signed [WIDTH-1:0] a_y;
    logic signed [WIDTH-1:0] a_z;
    logic signed [WIDTH-1:0] a_w;
    logic signed [WIDTH-1:0] b_x;
    logic signed [WIDTH-1:0] b_y;
    logic signed [WIDTH-1:0] b_z;
    logic signed [WIDTH-1:0] b_w;

    modport source (
        output valid, cmd, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w,
        input  ready
    );
    modport sink (
        input  valid, cmd, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w,
        output ready
    );
endinterface

interface qalu_res_if import qalu_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [WIDTH-1:0] res_x;
    logic signed [WIDTH-1:0] res_y;
    logic signed [WIDTH-1:0] res_z;
    logic signed [WIDTH-1:0] res_w;
    logic signed [WIDTH-1:0] scalar_out;
    logic                    zero_divisor;
    logic                    saturated;

    modport source (
        output valid, res_x, res_y, res_z, res_w, scalar_out, zero_divisor, saturated,
        input  ready
    );
    modport sink (
        input  valid, res_x, res_y, res_z, res_w, scalar_out, zero_divisor, saturated,
        output ready
    );
endinterface

`default_nettype wire

FILE: src/qalu_front.sv
// qalu_front: four-stage front end: products, exact sums, rounding and clamping for
// multiply, conjugate and dot, plus the sum of squares. Depends on qalu_pkg.
`default_nettype none

module qalu_front import qalu_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_en,
    input  wire logic   i_valid,
    input  wire t_req   i_req,
    output logic        o_valid,
    output t_front      o_pay
);

    function automatic logic signed [SUM_W-1:0] sxp(input logic [PROD_W-1:0] p);
        return $signed({{(SUM_W - PROD_W){p[PROD_W-1]}}, p});
    endfunction

    // stage 1: input register
    logic r_v1;
    t_req r_req1;

    // stage 2: products
    logic                    r_v2;
    t_cmd                    r_cmd2;
    logic [3:0][WIDTH-1:0]   r_a2;
    logic [15:0][PROD_W-1:0] r_ab2;
    logic [3:0][PROD_W-1:0]  r_aa2;
    logic [15:0][PROD_W-1:0] n_ab;
    logic [3:0][PROD_W-1:0]  n_aa;

    // stage 3: sums
    logic                   r_v3;
    t_cmd                   r_cmd3;
    logic [3:0][WIDTH-1:0]  r_a3;
    logic [3:0][SUM_W-1:0]  r_sum3;
    logic [SUM_W-1:0]       r_dot3;
    logic [SQ_W-1:0]        r_sq3;
    logic [3:0][SUM_W-1:0]  n_sum;
    logic [SUM_W-1:0]       n_dot;
    logic [SQ_W-1:0]        n_sq;
    logic signed [SUM_W-1:0] e [16];

    // stage 4: results
    logic   r_v4;
    t_front r_out4;
    t_front n_out;
    t_sat   cm [4];
    t_sat   cc [3];
    t_sat   cd;

    always_comb begin
        logic signed [PROD_W-1:0] p;
        for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++) begin
                p = $signed(r_req1.a[i]) * $signed(r_req1.b[j]);
                n_ab[i*4+j] = p;
            end
            p = $signed(r_req1.a[i]) * $signed(r_req1.a[i]);
            n_aa[i] = p;
        end
    end

    always_comb begin
        for (int k = 0; k < 16; k++) begin
            e[k] = sxp(r_ab2[k]);
        end
        // e[i*4+j] is a_i * b_j, index 3 is the scalar part
        n_sum[0] = e[12] + e[3] + e[6] - e[9];
        n_sum[1] = e[13] - e[2] + e[7] + e[8];
        n_sum[2] = e[14] + e[1] - e[4] + e[11];
        n_sum[3] = e[15] - e[0] - e[5] - e[10];
        n_dot    = e[0] + e[5] + e[10] + e[15];
        n_sq     = SQ_W'(r_aa2[0]) + SQ_W'(r_aa2[1]) + SQ_W'(r_aa2[2]) + SQ_W'(r_aa2[3]);
    end

    always_comb begin
        n_out     = '0;
        n_out.cmd = r_cmd3;
        n_out.sq  = r_sq3;
        for (int i = 0; i < 4; i++) begin
            n_out.neg[i] = r_a3[i][WIDTH-1];
            n_out.mag[i] = r_a3[i][WIDTH-1] ? (~r_a3[i]) + WIDTH'(1) : r_a3[i];
            cm[i]        = clamp_fn(rnd_fn(r_sum3[i]));
        end
        for (int i = 0; i < 3; i++) begin
            cc[i] = clamp_fn(-sext_fn(r_a3[i]));
        end
        cd = clamp_fn(rnd_fn(r_dot3));
        case (r_cmd3)
            CMD_MUL: begin
                n_out.res.x   = cm[0].val;
                n_out.res.y   = cm[1].val;
                n_out.res.z   = cm[2].val;
                n_out.res.w   = cm[3].val;
                n_out.res.sat = cm[0].sat | cm[1].sat | cm[2].sat | cm[3].sat;
            end
            CMD_CONJ: begin
                n_out.res.x   = cc[0].val;
                n_out.res.y   = cc[1].val;
                n_out.res.z   = cc[2].val;
                n_out.res.w   = r_a3[3];
                n_out.res.sat = cc[0].sat | cc[1].sat | cc[2].sat;
            end
            CMD_DOT: begin
                n_out.res.s   = cd.val;
                n_out.res.sat = cd.sat;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_req1 <= i_req;
            r_cmd2 <= r_req1.cmd;
            r_a2   <= r_req1.a;
            r_ab2  <= n_ab;
            r_aa2  <= n_aa;
            r_cmd3 <= r_cmd2;
            r_a3   <= r_a2;
            r_sum3 <= n_sum;
            r_dot3 <= n_dot;
            r_sq3  <= n_sq;
            r_out4 <= n_out;
        end
    end

    assign o_valid = r_v4;
    assign o_pay   = r_out4;

endmodule

`default_nettype wire

FILE: src/qalu_sqrt.sv
// qalu_sqrt: pipelined integer square root of the sum of squares, one root bit per
// stage, front-end payload carried alongside. Depends on qalu_pkg.
`default_nettype none

module qalu_sqrt import qalu_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_en,
    input  wire logic        i_valid,
    input  wire t_front      i_pay,
    output logic             o_valid,
    output t_front           o_pay,
    output logic [ROOT_W-1:0] o_root,
    output logic [SQ_W-1:0]  o_rem
);

    localparam int TW = SQ_W + 2;

    logic              r_v    [ROOT_W];
    t_front            r_pay  [ROOT_W];
    logic [SQ_W-1:0]   r_rem  [ROOT_W];
    logic [ROOT_W-1:0] r_root [ROOT_W];

    genvar s;
    for (s = 0; s < ROOT_W; s++) begin : g_stage
        localparam int K = ROOT_W - 1 - s;
        logic              v_in;
        t_front            p_in;
        logic [TW-1:0]     rem_in;
        logic [ROOT_W-1:0] root_in;
        logic [TW-1:0]     trial;
        logic [SQ_W-1:0]   n_rem;
        logic [ROOT_W-1:0] n_root;

        if (s == 0) begin : g_first
            assign v_in    = i_valid;
            assign p_in    = i_pay;
            assign rem_in  = TW'(i_pay.sq);
            assign root_in = '0;
        end else begin : g_next
            assign v_in    = r_v[s-1];
            assign p_in    = r_pay[s-1];
            assign rem_in  = TW'(r_rem[s-1]);
            assign root_in = r_root[s-1];
        end

        // (2r + 2^k) * 2^k, the growth of the square when bit k is set
        assign trial = (TW'(root_in) << (K + 1)) + (TW'(1) << (2 * K));

        always_comb begin
            if (trial <= rem_in) begin
                n_rem  = SQ_W'(rem_in - trial);
                n_root = root_in | (ROOT_W'(1) << K);
            end else begin
                n_rem  = SQ_W'(rem_in);
                n_root = root_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s] <= 1'b0;
            end else if (i_en) begin
                r_v[s] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_pay[s]  <= p_in;
                r_rem[s]  <= n_rem;
                r_root[s] <= n_root;
            end
        end
    end

    assign o_valid = r_v[ROOT_W-1];
    assign o_pay   = r_pay[ROOT_W-1];
    assign o_root  = r_root[ROOT_W-1];
    assign o_rem   = r_rem[ROOT_W-1];

endmodule

`default_nettype wire

FILE: src/qalu_div.sv
// qalu_div: norm rounding, divider setup, four-lane pipelined restoring divider for
// inverse and unit, and the final result stage. Depends on qalu_pkg.
`default_nettype none

module qalu_div import qalu_pkg::*; (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_en,
    input  wire logic         i_valid,
    input  wire t_front       i_pay,
    input  wire logic [ROOT_W-1:0] i_root,
    input  wire logic [SQ_W-1:0]   i_rem,
    output logic              o_valid,
    output t_res              o_res
);

    // index 0 is the setup stage, 1..QB the quotient steps
    logic                  r_v   [QB+1];
    t_cmd                  r_cmd [QB+1];
    t_res                  r_res [QB+1];
    logic [DIV_W-1:0]      r_d   [QB+1];
    logic [3:0]            r_neg [QB+1];
    logic [3:0][DIV_W-1:0] r_rem [QB+1];
    // numerator low bits shift out at the top while quotient bits shift in
    logic [3:0][QB-1:0]    r_nq  [QB+1];

    logic                  r_ov;
    t_res                  r_ores;

    // setup
    logic              up;
    logic [ROOT_W-1:0] nr;
    logic              is_div;
    logic              zd;
    t_sat              nc;
    t_res              n_res;
    logic [DIV_W-1:0]  n_d;
    logic [3:0]        n_neg;
    logic [3:0][DIV_W-1:0] n_rem0;
    logic [3:0][QB-1:0]    n_nq0;

    always_comb begin
        logic [DIV_W-1:0] num;
        up     = i_rem > SQ_W'(i_root);
        nr     = i_root + ROOT_W'(up);
        is_div = (i_pay.cmd == CMD_INV) || (i_pay.cmd == CMD_UNIT);
        zd     = is_div && (i_pay.sq == '0);
        nc     = clamp_fn(SUM_W'(nr));
        n_res    = i_pay.res;
        n_res.zd = zd;
        if (i_pay.cmd == CMD_NORM) begin
            n_res.s   = nc.val;
            n_res.sat = nc.sat;
        end
        if (i_pay.cmd == CMD_INV) begin
            n_d = DIV_W'({i_pay.sq, 1'b0});
        end else begin
            n_d = DIV_W'({nr, 1'b0});
        end
        for (int l = 0; l < 4; l++) begin
            // numerators carry 2m + d so the quotient comes out rounded
            if (i_pay.cmd == CMD_INV) begin
                num = DIV_W'({i_pay.mag[l], {(2 * FRAC_BITS + 1){1'b0}}}) + DIV_W'(i_pay.sq);
                n_neg[l] = (l == 3) ? i_pay.neg[l] : !i_pay.neg[l];
            end else begin
                num = DIV_W'({i_pay.mag[l], {(FRAC_BITS + 1){1'b0}}}) + DIV_W'(nr);
                n_neg[l] = i_pay.neg[l];
            end
            n_rem0[l] = num >> QB;
            n_nq0[l]  = num[QB-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cmd[0] <= i_pay.cmd;
            r_res[0] <= n_res;
            r_d[0]   <= n_d;
            r_neg[0] <= n_neg;
            r_rem[0] <= n_rem0;
            r_nq[0]  <= n_nq0;
        end
    end

    genvar s;
    for (s = 1; s <= QB; s++) begin : g_step
        logic [3:0][DIV_W-1:0] n_rem;
        logic [3:0][QB-1:0]    n_nq;

        always_comb begin
            logic [DIV_W:0] t;
            logic           ge;
            for (int l = 0; l < 4; l++) begin
                t  = {r_rem[s-1][l], r_nq[s-1][l][QB-1]};
                ge = t >= {1'b0, r_d[s-1]};
                if (ge) begin
                    n_rem[l] = DIV_W'(t - {1'b0, r_d[s-1]});
                end else begin
                    n_rem[l] = DIV_W'(t);
                end
                n_nq[l] = {r_nq[s-1][l][QB-2:0], ge};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s] <= 1'b0;
            end else if (i_en) begin
                r_v[s] <= r_v[s-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_cmd[s] <= r_cmd[s-1];
                r_res[s] <= r_res[s-1];
                r_d[s]   <= r_d[s-1];
                r_neg[s] <= r_neg[s-1];
                r_rem[s] <= n_rem;
                r_nq[s]  <= n_nq;
            end
        end
    end

    // sign, clamp and merge
    t_sat cq [4];
    t_res n_fin;

    always_comb begin
        logic signed [SUM_W-1:0] qv;
        for (int l = 0; l < 4; l++) begin
            qv    = $signed(SUM_W'(r_nq[QB][l]));
            cq[l] = clamp_fn(r_neg[QB][l] ? -qv : qv);
        end
        n_fin = r_res[QB];
        if (((r_cmd[QB] == CMD_INV) || (r_cmd[QB] == CMD_UNIT)) && !r_res[QB].zd) begin
            n_fin.x   = cq[0].val;
            n_fin.y   = cq[1].val;
            n_fin.z   = cq[2].val;
            n_fin.w   = cq[3].val;
            n_fin.sat = r_res[QB].sat | cq[0].sat | cq[1].sat | cq[2].sat | cq[3].sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_en) begin
            r_ov <= r_v[QB];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ores <= n_fin;
        end
    end

    assign o_valid = r_ov;
    assign o_res   = r_ores;

endmodule

`default_nettype wire

FILE: src/quaternion_alu.sv
// quaternion_alu: top level, chains front end, square root and divider and ends in an
// output register with a skid slot. Depends on qalu_pkg, qalu_if and the qalu_ modules.
//
// Quaternion unit in signed Q16.16: Hamilton product, conjugate, dot, norm, inverse and
// unit, one request per cycle while ready is high. Most of the pipe depth comes from the
// 33-stage square root (one root bit per stage) followed by the 33-stage four-lane
// divider (one quotient bit per stage); every opcode walks the full pipe, so results
// leave in request order. Each value is rounded at most once, to nearest with ties away
// from zero, then clamped, which sets saturated. Inverse or unit of the zero quaternion
// gives all zeros with zero_divisor set. Opcodes 6 and 7 give all zeros.
// ready falls only when the output is stalled and its skid slot already holds a result.
`default_nettype none

module quaternion_alu import qalu_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    qalu_req_if.sink    i_req,
    qalu_res_if.source  o_res
);

    logic        en;
    logic        slot_free;
    t_req        req;
    logic        front_v;
    t_front      front_pay;
    logic        sqrt_v;
    t_front      sqrt_pay;
    logic [ROOT_W-1:0] sqrt_root;
    logic [SQ_W-1:0]   sqrt_rem;
    logic        pipe_v;
    t_res        pipe_res;

    logic        r_out_valid;
    t_res        r_out;
    logic        r_skid_valid;
    t_res        r_skid;

    assign en          = !r_skid_valid;
    assign i_req.ready = en;
    assign slot_free   = !r_out_valid || o_res.ready;

    assign req.cmd = t_cmd'(i_req.cmd);
    assign req.a   = {i_req.a_w, i_req.a_z, i_req.a_y, i_req.a_x};
    assign req.b   = {i_req.b_w, i_req.b_z, i_req.b_y, i_req.b_x};

    qalu_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_req.valid),
        .i_req   (req),
        .o_valid (front_v),
        .o_pay   (front_pay)
    );

    qalu_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (front_v),
        .i_pay   (front_pay),
        .o_valid (sqrt_v),
        .o_pay   (sqrt_pay),
        .o_root  (sqrt_root),
        .o_rem   (sqrt_rem)
    );

    qalu_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (sqrt_v),
        .i_pay   (sqrt_pay),
        .i_root  (sqrt_root),
        .i_rem   (sqrt_rem),
        .o_valid (pipe_v),
        .o_res   (pipe_res)
    );

    // output register plus one skid slot; the pipe freezes only while the slot is full
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (r_skid_valid) begin
                if (slot_free) begin
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end
            end else if (pipe_v) begin
                if (slot_free) begin
                    r_out_valid <= 1'b1;
                end else begin
                    r_skid_valid <= 1'b1;
                end
            end else if (slot_free) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (slot_free) begin
                r_out <= r_skid;
            end
        end else if (pipe_v) begin
            if (slot_free) begin
                r_out <= pipe_res;
            end else begin
                r_skid <= pipe_res;
            end
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.res_x        = r_out.x;
    assign o_res.res_y        = r_out.y;
    assign o_res.res_z        = r_out.z;
    assign o_res.res_w        = r_out.w;
    assign o_res.scalar_out   = r_out.s;
    assign o_res.zero_divisor = r_out.zd;
    assign o_res.saturated    = r_out.sat;

endmodule

`default_nettype wire

FILE: src/qalu_checker.sv
// qalu_checker: port-level assertions for quaternion_alu and the bind that attaches them.
// Depends on qalu_pkg for the component width.
`default_nettype none

module qalu_checker import qalu_pkg::*; (
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             i_req_ready,
    input wire logic             i_res_valid,
    input wire logic             i_res_ready,
    input wire logic [WIDTH-1:0] i_res_x,
    input wire logic [WIDTH-1:0] i_res_y,
    input wire logic [WIDTH-1:0] i_res_z,
    input wire logic [WIDTH-1:0] i_res_w,
    input wire logic [WIDTH-1:0] i_scalar,
    input wire logic             i_zd,
    input wire logic             i_sat
);

    // a stalled result stays put
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && !i_res_ready) |=> (i_res_valid && $stable(i_res_x)
            && $stable(i_res_y) && $stable(i_res_z) && $stable(i_res_w)
            && $stable(i_scalar) && $stable(i_zd) && $stable(i_sat)))
        else $error("result changed while stalled");

    // request side only backs up behind a stalled result
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_req_ready |-> $past(i_res_valid && !i_res_ready))
        else $error("request stalled without output backpressure");

    // zero divisor means an all-zero result without saturation
    a_zd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && i_zd) |-> (i_res_x == '0 && i_res_y == '0 && i_res_z == '0
            && i_res_w == '0 && i_scalar == '0 && !i_sat))
        else $error("zero divisor with nonzero result");

    // scalar and quaternion results never share an item
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && i_scalar != '0) |-> (i_res_x == '0 && i_res_y == '0
            && i_res_z == '0 && i_res_w == '0))
        else $error("scalar and quaternion result both nonzero");

endmodule

bind quaternion_alu qalu_checker u_qalu_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_ready (i_req.ready),
    .i_res_valid (o_res.valid),
    .i_res_ready (o_res.ready),
    .i_res_x     (o_res.res_x),
    .i_res_y     (o_res.res_y),
    .i_res_z     (o_res.res_z),
    .i_res_w     (o_res.res_w),
    .i_scalar    (o_res.scalar_out),
    .i_zd        (o_res.zero_divisor),
    .i_sat       (o_res.saturated)
);

`default_nettype wire

FILE: tb/quaternion_alu_test.sv
// quaternion_alu_test: self-checking bench for the quaternion unit, predicts every result
// in fixed point and compares it field by field. Depends on qalu_pkg, qalu_if, quaternion_alu.
`timescale 1ns / 100ps

module quaternion_alu_test;
    import qalu_pkg::*;

    localparam logic [2:0] CMD_SPARE6 = 3'd6;
    localparam logic [2:0] CMD_SPARE7 = 3'd7;
    localparam int         CYCLE_LIMIT = 300000;
    localparam int         DRAIN_CYCLES = 150;
    localparam logic signed [WIDTH-1:0] Q_MAX = 32'sh7fffffff;
    localparam logic signed [WIDTH-1:0] Q_MIN = 32'sh80000000;
    localparam logic signed [WIDTH-1:0] Q_ONE = 32'sh00010000;

    typedef logic signed [159:0] wint;
    typedef logic signed [WIDTH-1:0] quat_t [4];

    logic i_clk;
    logic i_rst_n;
    int   errors;
    int   cycles;
    bit   idle_on;
    int   stall_left;
    t_res pending_results [$];

    qalu_req_if req_if ();
    qalu_res_if res_if ();

    quaternion_alu dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_res   (res_if)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t timeout", $time);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // x / d for d > 0, nearest with ties away from zero
    function automatic wint div_round(wint x, wint d);
        wint m;
        wint q;
        m = (x < 0) ? -x : x;
        q = (2 * m + d) / (2 * d);
        return (x < 0) ? -q : q;
    endfunction

    function automatic wint sqrt_round(wint n);
        wint r;
        wint t;
        r = '0;
        for (int k = 39; k >= 0; k--) begin
            t = r | (wint'(1) << k);
            if (t * t <= n) r = t;
        end
        if (n - r * r > r) r = r + 1;
        return r;
    endfunction

    function automatic logic signed [WIDTH-1:0] clamp(wint v, inout logic flag);
        if (v > wint'(Q_MAX)) begin
            flag = 1'b1;
            return Q_MAX;
        end
        if (v < wint'(Q_MIN)) begin
            flag = 1'b1;
            return Q_MIN;
        end
        return v[WIDTH-1:0];
    endfunction

    function automatic t_res quat_result(logic [2:0] op, quat_t a, quat_t b);
        wint  av [4];
        wint  bv [4];
        wint  v [4];
        wint  sq;
        wint  nr;
        wint  one;
        logic signed [WIDTH-1:0] q [4];
        logic sat;
        t_res r;
        r = '0;
        sat = 1'b0;
        one = wint'(1) << FRAC_BITS;
        sq = '0;
        for (int i = 0; i < 4; i++) begin
            av[i] = a[i];
            bv[i] = b[i];
            q[i] = '0;
            sq = sq + av[i] * av[i];
        end
        case (op)
            CMD_MUL: begin
                v[0] = av[3]*bv[0] + av[0]*bv[3] + av[1]*bv[2] - av[2]*bv[1];
                v[1] = av[3]*bv[1] - av[0]*bv[2] + av[1]*bv[3] + av[2]*bv[0];
                v[2] = av[3]*bv[2] + av[0]*bv[1] - av[1]*bv[0] + av[2]*bv[3];
                v[3] = av[3]*bv[3] - av[0]*bv[0] - av[1]*bv[1] - av[2]*bv[2];
                for (int i = 0; i < 4; i++) q[i] = clamp(div_round(v[i], one), sat);
            end
            CMD_CONJ: begin
                for (int i = 0; i < 3; i++) q[i] = clamp(-av[i], sat);
                q[3] = clamp(av[3], sat);
            end
            CMD_DOT: begin
                v[0] = av[0]*bv[0] + av[1]*bv[1] + av[2]*bv[2] + av[3]*bv[3];
                r.s = clamp(div_round(v[0], one), sat);
            end
            CMD_NORM: r.s = clamp(sqrt_round(sq), sat);
            CMD_INV: begin
                if (sq == 0) r.zd = 1'b1;
                else
                    for (int i = 0; i < 4; i++)
                        q[i] = clamp(div_round(((i < 3) ? -av[i] : av[i]) <<< (2 * FRAC_BITS),
                                               sq), sat);
            end
            CMD_UNIT: begin
                nr = sqrt_round(sq);
                if (nr == 0) r.zd = 1'b1;
                else
                    for (int i = 0; i < 4; i++)
                        q[i] = clamp(div_round(av[i] <<< FRAC_BITS, nr), sat);
            end
            default: ;
        endcase
        r.x = q[0];
        r.y = q[1];
        r.z = q[2];
        r.w = q[3];
        r.sat = sat;
        return r;
    endfunction

    function automatic quat_t mkq(logic signed [WIDTH-1:0] x, logic signed [WIDTH-1:0] y,
                                  logic signed [WIDTH-1:0] z, logic signed [WIDTH-1:0] w);
        quat_t q;
        q[0] = x;
        q[1] = y;
        q[2] = z;
        q[3] = w;
        return q;
    endfunction

    task automatic send_item(logic [2:0] op, quat_t a, quat_t b);
        @(negedge i_clk);
        req_if.valid <= 1'b1;
        req_if.cmd   <= op;
        req_if.a_x <= a[0];
        req_if.a_y <= a[1];
        req_if.a_z <= a[2];
        req_if.a_w <= a[3];
        req_if.b_x <= b[0];
        req_if.b_y <= b[1];
        req_if.b_z <= b[2];
        req_if.b_w <= b[3];
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        pending_results.push_back(quat_result(op, a, b));
        if (idle_on && $urandom_range(0, 3) == 0) begin
            @(negedge i_clk);
            req_if.valid <= 1'b0;
            repeat ($urandom_range(0, 4)) @(negedge i_clk);
        end
    endtask

    // receiver stalls in bursts
    always @(negedge i_clk) begin
        logic rdy;
        if (stall_left > 0) begin
            stall_left--;
            rdy = 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 4);
            rdy = 1'b0;
        end else begin
            rdy = 1'b1;
        end
        res_if.ready <= rdy;
    end

    task automatic check_field(string name, logic [WIDTH-1:0] exp_v, logic [WIDTH-1:0] got_v);
        if (exp_v !== got_v) begin
            errors++;
            $display("%0t %s mismatch: expected %h actual %h", $time, name, exp_v, got_v);
        end
    endtask

    always @(posedge i_clk) begin
        t_res e;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t unexpected result: expected none actual %h %h %h %h %h", $time,
                         res_if.res_x, res_if.res_y, res_if.res_z, res_if.res_w,
                         res_if.scalar_out);
            end else begin
                e = pending_results.pop_front();
                check_field("res_x", e.x, res_if.res_x);
                check_field("res_y", e.y, res_if.res_y);
                check_field("res_z", e.z, res_if.res_z);
                check_field("res_w", e.w, res_if.res_w);
                check_field("scalar_out", e.s, res_if.scalar_out);
                check_field("zero_divisor", e.zd, res_if.zero_divisor);
                check_field("saturated", e.sat, res_if.saturated);
            end
        end
    end

    function automatic logic signed [WIDTH-1:0] rand_comp();
        case ($urandom_range(0, 9))
            0: return '0;
            1: case ($urandom_range(0, 3))
                0: return Q_MAX;
                1: return Q_MIN;
                2: return 32'sd1;
                default: return -32'sd1;
            endcase
            2, 3, 4: return $urandom;
            default: return $signed($urandom_range(0, 262143)) - 32'sd131072;
        endcase
    endfunction

    task automatic test_extremes();
        quat_t zq;
        zq = mkq(0, 0, 0, 0);
        send_item(CMD_MUL, mkq(Q_MAX, Q_MAX, Q_MAX, Q_MAX), mkq(Q_MAX, Q_MAX, Q_MAX, Q_MAX));
        send_item(CMD_MUL, mkq(Q_MIN, Q_MIN, Q_MIN, Q_MIN), mkq(Q_MIN, Q_MAX, Q_MIN, Q_MAX));
        send_item(CMD_MUL, mkq(0, 0, 0, Q_ONE), mkq(32'sd5, -32'sd7, Q_MAX, Q_MIN));
        send_item(CMD_CONJ, mkq(Q_MIN, Q_MAX, 32'sd1, Q_MIN), zq);
        send_item(CMD_CONJ, mkq(-32'sd1, 0, Q_MAX, Q_MAX), zq);
        send_item(CMD_DOT, mkq(Q_MIN, Q_MIN, Q_MIN, Q_MIN), mkq(Q_MIN, Q_MIN, Q_MIN, Q_MIN));
        send_item(CMD_DOT, mkq(Q_ONE, 2 * Q_ONE, 0, -Q_ONE), mkq(Q_ONE, Q_ONE, Q_MAX, 3 * Q_ONE));
        send_item(CMD_NORM, mkq(Q_MIN, Q_MIN, Q_MIN, Q_MIN), zq);
        send_item(CMD_NORM, mkq(3 * Q_ONE, 4 * Q_ONE, 0, 0), zq);
        send_item(CMD_INV, mkq(Q_ONE, 0, 0, 0), zq);
        send_item(CMD_INV, mkq(Q_MAX, Q_MIN, Q_MAX, Q_MIN), zq);
        send_item(CMD_UNIT, mkq(Q_MAX, Q_MIN, Q_MAX, Q_MIN), zq);
        send_item(CMD_UNIT, mkq(0, -32'sd3, 0, 32'sd4), zq);
    endtask

    task automatic test_special_cases();
        quat_t zq;
        zq = mkq(0, 0, 0, 0);
        // zero divisor
        send_item(CMD_INV, zq, mkq(Q_MAX, Q_MIN, 1, -1));
        send_item(CMD_UNIT, zq, mkq(Q_MIN, Q_MAX, -1, 1));
        // tiny input makes the inverse overflow
        send_item(CMD_INV, mkq(0, 0, 32'sd1, 0), zq);
        send_item(CMD_INV, mkq(0, 0, 0, -32'sd1), zq);
        // rounding ties, both signs
        send_item(CMD_MUL, mkq(0, 0, 0, 32'sd1), mkq(0, 0, 0, 32'sh8000));
        send_item(CMD_MUL, mkq(0, 0, 0, -32'sd1), mkq(0, 0, 0, 32'sh8000));
        send_item(CMD_DOT, mkq(32'sd1, 0, 0, 0), mkq(-32'sh18000, 0, 0, 0));
        // unused opcodes
        send_item(CMD_SPARE6, mkq(Q_MAX, 1, 2, 3), mkq(4, 5, 6, Q_MIN));
        send_item(CMD_SPARE7, mkq(Q_MIN, 0, 0, 0), mkq(Q_MAX, 0, 0, 0));
    endtask

    task automatic test_random(int count);
        logic [2:0] op;
        quat_t a;
        quat_t b;
        for (int n = 0; n < count; n++) begin
            op = ($urandom_range(0, 29) == 0) ? 3'($urandom_range(6, 7)) : 3'd0;
            if (op == 0) op = 3'($urandom_range(0, 5));
            for (int i = 0; i < 4; i++) begin
                a[i] = rand_comp();
                b[i] = rand_comp();
            end
            if ((op == CMD_INV || op == CMD_UNIT) && $urandom_range(0, 19) == 0)
                a = mkq(0, 0, 0, 0);
            send_item(op, a, b);
        end
    endtask

    initial begin
        idle_on = 1'b1;
        i_rst_n = 1'b0;
        req_if.valid = 1'b0;
        req_if.cmd = CMD_MUL;
        req_if.a_x = '0;
        req_if.a_y = '0;
        req_if.a_z = '0;
        req_if.a_w = '0;
        req_if.b_x = '0;
        req_if.b_y = '0;
        req_if.b_z = '0;
        req_if.b_w = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_extremes();
        test_special_cases();
        test_random(1700);
        idle_on = 1'b0;
        test_random(250);

        @(negedge i_clk);
        req_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

FILE: files.f
src/qalu_pkg.sv
src/qalu_if.sv
src/qalu_front.sv
src/qalu_sqrt.sv
src/qalu_div.sv
src/quaternion_alu.sv
src/qalu_checker.sv
tb/quaternion_alu_test.sv
